/* rtl/core/wfba_pkg.sv */
// Package for the worst-fit block allocator.
// Holds sizes, field widths, function codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package wfba_pkg;

  localparam int NUM_BLOCKS = 32;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS   = 6;   // width of block_count, also holds NUM_BLOCKS

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef struct packed {
    logic load;    // write a block size, mark it free
    logic start;   // latch job size, clear best, rewind scan
    logic step;    // read the next block
    logic finish;  // mark winner used, load output register
  } wfba_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } wfba_status_t;

endpackage

`default_nettype wire

/* rtl/core/wfba_ifaces.sv */
// Channel interfaces for the worst-fit block allocator: request and response.
// Depends on wfba_pkg.
`default_nettype none

interface wfba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [wfba_pkg::IDX_BITS-1:0]  block_index;
  logic [wfba_pkg::SIZE_BITS-1:0] size_value;

  modport source (output valid, func, block_index, size_value, input ready);
  modport sink   (input valid, func, block_index, size_value, output ready);
endinterface

interface wfba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [wfba_pkg::IDX_BITS-1:0]  chosen_block;
  logic [wfba_pkg::SIZE_BITS-1:0] leftover;

  modport source (output valid, found, chosen_block, leftover, input ready);
  modport sink   (input valid, found, chosen_block, leftover, output ready);
endinterface

`default_nettype wire

/* rtl/core/wfba_ctrl.sv */
// Controller for the worst-fit block allocator: idle / scan / finish sequencing.
// Depends on wfba_pkg.
`default_nettype none

module wfba_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  input  wire logic                   req_func,
  output logic                        req_ready,
  input  wire wfba_pkg::wfba_status_t status,
  output wfba_pkg::wfba_cmd_t         cmd
);
  import wfba_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign accept = req_valid && req_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept && (req_func == FUNC_LOAD);
    cmd.start  = accept && (req_func == FUNC_ALLOC);
    cmd.step   = (state == SCAN) && !status.scan_done;
    cmd.finish = (state == FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.start) begin
            state     <= SCAN;
            req_ready <= 1'b0;
          end
        end
        SCAN: begin
          // last compare lands at this edge
          if (status.scan_done) state <= FINISH;
        end
        FINISH: begin
          if (status.out_free) begin
            state     <= IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wfba_datapath.sv */
// Datapath for the worst-fit block allocator: size memory, used flags,
// scan counter, best-fit tracking and the output register. Depends on wfba_pkg.
`default_nettype none

module wfba_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [wfba_pkg::CNT_BITS-1:0]  cfg_wdata,
  input  wire logic [wfba_pkg::IDX_BITS-1:0]  req_block_index,
  input  wire logic [wfba_pkg::SIZE_BITS-1:0] req_size_value,
  input  wire wfba_pkg::wfba_cmd_t            cmd,
  output wfba_pkg::wfba_status_t              status,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output logic                                rsp_found,
  output logic [wfba_pkg::IDX_BITS-1:0]       rsp_chosen_block,
  output logic [wfba_pkg::SIZE_BITS-1:0]      rsp_leftover
);
  import wfba_pkg::*;

  logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] used;

  logic [CNT_BITS-1:0]  block_count;
  logic [CNT_BITS-1:0]  limit;
  logic [CNT_BITS-1:0]  scan_idx;
  logic [SIZE_BITS-1:0] job_size;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 cmp_valid;
  logic [IDX_BITS-1:0]  cmp_idx;
  logic                 have;
  logic [IDX_BITS-1:0]  best_idx;
  logic [SIZE_BITS-1:0] best_left;
  logic [SIZE_BITS-1:0] left;
  logic                 fits;
  logic                 take;

  always_ff @(posedge clk) begin
    if (rst) block_count <= '0;
    else if (cfg_we) block_count <= cfg_wdata;
  end

  assign limit = (block_count > CNT_BITS'(NUM_BLOCKS)) ? CNT_BITS'(NUM_BLOCKS) : block_count;

  assign status.scan_done = (scan_idx >= limit);
  assign status.out_free  = !rsp_valid || rsp_ready;

  // size memory: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.load) size_mem[req_block_index] <= req_size_value;
    if (cmd.step) rd_data <= size_mem[scan_idx[IDX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.load) begin
      used[req_block_index] <= 1'b0;
    end else if (cmd.finish && have) begin
      used[best_idx] <= 1'b1;
    end
  end

  assign left = rd_data - job_size;
  assign fits = cmp_valid && !used[cmp_idx] && (rd_data >= job_size);
  assign take = fits && (!have || (left > best_left));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      have      <= 1'b0;
    end else begin
      cmp_valid <= cmd.step;
      if (cmd.start) begin
        scan_idx <= '0;
        have     <= 1'b0;
      end else begin
        if (cmd.step) scan_idx <= scan_idx + CNT_BITS'(1);
        if (take) have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) job_size <= req_size_value;
    if (cmd.step) cmp_idx <= scan_idx[IDX_BITS-1:0];
    if (take) begin
      best_idx  <= cmp_idx;
      best_left <= left;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_found        <= have;
      rsp_chosen_block <= have ? best_idx : '0;
      rsp_leftover     <= have ? best_left : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/worst_fit_block_allocator.sv */
// Worst-fit block allocator, top level.
// Usage:
//   req channel: func selects load (write block_index's size, mark it free) or
//   allocate (size_value is the job size). rsp channel: one transfer per
//   allocate, none per load: found, chosen_block, leftover.
//   cfg_we/cfg_wdata write block_count (blocks scanned from index 0, capped at 32);
//   write it only while the block is idle.
// Timing:
//   A load leaves req ready high; the next request is accepted on the following cycle.
//   An allocate scans one block per cycle through the size memory's single read
//   port, then loads the result into the output register; no new request is
//   accepted until that result has been loaded.
//   The result sits in an output register; while rsp is stalled the block still
//   accepts loads and runs the next scan, and holds that result until the
//   register frees up.
// Reset (rst, synchronous): block_count = 0, all blocks free, no result pending.
//   Block sizes are not cleared; load a block before it falls in the scan range.
// Depends on wfba_pkg, wfba_ifaces, wfba_ctrl, wfba_datapath.
`default_nettype none

module worst_fit_block_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [wfba_pkg::CNT_BITS-1:0] cfg_wdata,
  wfba_req_if.sink                           req,
  wfba_rsp_if.source                         rsp
);
  import wfba_pkg::*;

  wfba_cmd_t    cmd;
  wfba_status_t status;

  wfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wfba_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_block_index  (req.block_index),
    .req_size_value   (req.size_value),
    .cmd              (cmd),
    .status           (status),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found        (rsp.found),
    .rsp_chosen_block (rsp.chosen_block),
    .rsp_leftover     (rsp.leftover)
  );

endmodule

`default_nettype wire
